@@ rtl/snk_pkg.sv @@
package snk_pkg;

  // Fractional turn constant 1/(2*pi) in Q0.64, split into 32-bit halves.
  localparam logic [31:0] INV_TWO_PI_LO = 32'h9391054A;
  localparam logic [31:0] INV_TWO_PI_HI = 32'h28BE60DB;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [16:0] ONE_Q16     = 17'h1_0000;

  // Exact reciprocal multipliers for the Horner divisors 110, 72, 42, 20, 6.
  // For a 32-bit dividend u: u / d == (u * DIV_MUL) >> DIV_SH.
  localparam int NUM_TERMS = 5;
  localparam logic [32:0] DIV_MUL [0:NUM_TERMS-1] = '{
    33'd4997780127, 33'd7635497416, 33'd6544712071, 33'd6871947674, 33'd5726623062
  };
  localparam int DIV_SH [0:NUM_TERMS-1] = '{39, 39, 38, 37, 35};

  // Horner stages: two for the first term, three for each further term.
  localparam int HORNER_STG = 3 * NUM_TERMS - 1;
  // Sine-squared pipeline: fold, angle, square, Horner, sine, square, round.
  localparam int SIN2_LAT   = 3 + HORNER_STG + 3;
  // Front end (product, magnitude, partial products, middle sum, phase).
  localparam int FRONT_LAT  = 5;
  localparam int ALIGN_DEPTH = FRONT_LAT + SIN2_LAT;
  // Edges from the accepting edge to the edge that takes the result.
  localparam int CORE_LAT   = ALIGN_DEPTH + 3;

endpackage

@@ rtl/snk_sin2.sv @@
module snk_sin2
  import snk_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] phase_i,
  output logic [16:0] sin2_o
);

  logic [30:0] v_r;
  logic [30:0] th_r;
  logic [31:0] t_r;
  logic [31:0] stg_r   [0:HORNER_STG-1];
  logic [31:0] t_ln_r  [0:HORNER_STG-1];
  logic [30:0] th_ln_r [0:HORNER_STG];
  logic [30:0] s_r;
  logic [30:0] sq_r;
  logic [16:0] sin2_r;

  logic [31:0] v_fold;
  logic [61:0] th_prod;
  logic [61:0] t_prod;
  logic [61:0] s_prod;
  logic [61:0] sq_prod;
  logic [30:0] sq_rnd;

  // Fold the half turn onto a quarter wave.
  always_comb begin
    v_fold = {1'b0, phase_i[30:0]};
    if (phase_i[30:0] > ONE_Q30) begin
      v_fold = 32'h8000_0000 - {1'b0, phase_i[30:0]};
    end
  end

  assign th_prod = 62'(v_r) * 62'(HALF_PI_Q30);
  assign t_prod  = 62'(th_r) * 62'(th_r);

  always_ff @(posedge clk) begin
    v_r  <= v_fold[30:0];
    th_r <= th_prod[60:30];
    t_r  <= t_prod[61:30];
  end

  // Alignment lines for t and theta next to the Horner stages. Theta is
  // ready in the cycle before t, so its line is one stage longer.
  always_ff @(posedge clk) begin
    t_ln_r[0]  <= t_r;
    th_ln_r[0] <= th_r;
    for (int i = 1; i < HORNER_STG; i++) begin
      t_ln_r[i]  <= t_ln_r[i-1];
    end
    for (int i = 1; i <= HORNER_STG; i++) begin
      th_ln_r[i] <= th_ln_r[i-1];
    end
  end

  // Horner evaluation of sin(th)/th: each term is a multiply by t (the first
  // term takes t itself), a reciprocal-multiply divide, and a subtract from one.
  for (genvar j = 0; j < HORNER_STG; j++) begin : g_horner
    localparam int K = (j == 0) ? 0 : j / 3;
    if (j % 3 == 0) begin : g_div
      logic [31:0] u;
      logic [64:0] q_prod;
      if (j == 0) begin : g_first
        assign u = t_r;
      end else begin : g_next
        assign u = stg_r[j-1];
      end
      assign q_prod = 65'(u) * 65'(DIV_MUL[K]);
      always_ff @(posedge clk) begin
        stg_r[j] <= 32'(q_prod >> DIV_SH[K]);
      end
    end else if (j % 3 == 1) begin : g_sub
      always_ff @(posedge clk) begin
        stg_r[j] <= {1'b0, ONE_Q30 - stg_r[j-1][30:0]};
      end
    end else begin : g_mul
      logic [62:0] m_prod;
      assign m_prod = 63'(t_ln_r[j-1]) * 63'(stg_r[j-1][30:0]);
      always_ff @(posedge clk) begin
        stg_r[j] <= m_prod[61:30];
      end
    end
  end

  assign s_prod  = 62'(th_ln_r[HORNER_STG]) * 62'(stg_r[HORNER_STG-1][30:0]);
  assign sq_prod = 62'(s_r) * 62'(s_r);
  assign sq_rnd  = sq_r + 31'd8192;

  always_ff @(posedge clk) begin
    s_r  <= (s_prod[61:30] > 32'(ONE_Q30)) ? ONE_Q30 : s_prod[60:30];
    sq_r <= sq_prod[60:30];
    sin2_r <= (sq_rnd[30:14] > ONE_Q16) ? ONE_Q16 : sq_rnd[30:14];
  end

  assign sin2_o = sin2_r;

endmodule

@@ rtl/snake_activation_core.sv @@
// Snake activation: out_y_out = x + sin(alpha*x)^2 * inv_beta, all Q16.16.
//
// Input channel: present in_sample_x, in_alpha and in_inv_beta and raise
// start. A transaction is accepted at a rising edge with start high and busy
// low. busy never rises in this design, so one transaction can be accepted
// in every cycle and the sustained rate is one element per clock.
//
// Result channel: out_valid is high for exactly one cycle with out_y_out and
// out_overflow; the result transaction is taken at the edge ending that
// cycle. The receiver cannot stall, and no stall is needed because the
// pipeline never holds data back. Results come out in input order.
//
// From the accepting edge to the edge that takes the result, the pipeline runs
// through five front-end stages (product, magnitude, four 32x32 partial
// products for the modulo-2*pi reduction, middle sum, phase), twenty stages
// of the sine-squared unit, and three back-end stages (scale, round, add and
// saturate). No stage chains more than one multiply, and no multiply is
// wider than 32x33 bits.
//
// Reset clears the valid bits of all stages; items in flight are dropped.
module snake_activation_core
  import snk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_sample_x,
  input  logic signed [31:0] in_alpha,
  input  logic signed [31:0] in_inv_beta,
  output logic               out_valid,
  output logic signed [31:0] out_y_out,
  output logic               out_overflow
);

  // Valid bits and the x / inv_beta alignment line, one entry per stage.
  logic               vld_r [0:ALIGN_DEPTH-1];
  logic signed [31:0] x_ln_r [0:ALIGN_DEPTH-1];
  logic signed [31:0] b_ln_r [0:ALIGN_DEPTH-1];

  logic signed [63:0] p_r;
  logic [62:0]        mag_r;
  logic [63:0]        pp_lo_r;
  logic [62:0]        pp_m1_r;
  logic [61:0]        pp_m2_r;
  logic [60:0]        pp_hi_r;
  logic [63:0]        mid_r;
  logic [31:0]        hi_r;
  logic [31:0]        phase_r;
  logic [16:0]        sin2;

  logic               vld_f1_r;
  logic               vld_f2_r;
  logic signed [49:0] scl_r;
  logic signed [31:0] x_f1_r;
  logic signed [33:0] term_r;
  logic signed [31:0] x_f2_r;
  logic               out_valid_r;
  logic signed [31:0] y_r;
  logic               ovf_r;

  logic signed [63:0] p_nxt;
  logic [63:0]        mag_nxt;
  logic signed [49:0] rnd_nxt;
  logic signed [34:0] sum_nxt;

  assign busy = 1'b0;

  // Valid bits travel with the data down the whole pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALIGN_DEPTH; i++) begin
        vld_r[i] <= 1'b0;
      end
      vld_f1_r    <= 1'b0;
      vld_f2_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r[0] <= start && !busy;
      for (int i = 1; i < ALIGN_DEPTH; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      vld_f1_r    <= vld_r[ALIGN_DEPTH-1];
      vld_f2_r    <= vld_f1_r;
      out_valid_r <= vld_f2_r;
    end
  end

  always_ff @(posedge clk) begin
    x_ln_r[0] <= in_sample_x;
    b_ln_r[0] <= in_inv_beta;
    for (int i = 1; i < ALIGN_DEPTH; i++) begin
      x_ln_r[i] <= x_ln_r[i-1];
      b_ln_r[i] <= b_ln_r[i-1];
    end
  end

  // Front end: exact product, its magnitude, then bits 64..95 of
  // magnitude * (1/(2*pi)) as the turn fraction. sin^2 is even, so the
  // sign of the product does not matter.
  assign p_nxt   = 64'(in_alpha) * 64'(in_sample_x);
  assign mag_nxt = p_r[63] ? (64'd0 - 64'(p_r)) : 64'(p_r);

  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    mag_r   <= mag_nxt[62:0];
    pp_lo_r <= 64'(mag_r[31:0]) * 64'(INV_TWO_PI_LO);
    pp_m1_r <= 63'(mag_r[62:32]) * 63'(INV_TWO_PI_LO);
    pp_m2_r <= 62'(mag_r[31:0]) * 62'(INV_TWO_PI_HI);
    pp_hi_r <= 61'(mag_r[62:32]) * 61'(INV_TWO_PI_HI);
    mid_r   <= 64'(pp_m1_r) + 64'(pp_m2_r) + 64'(pp_lo_r[63:32]);
    hi_r    <= pp_hi_r[31:0];
    phase_r <= hi_r + mid_r[63:32];
  end

  snk_sin2 u_sin2 (
    .clk     (clk),
    .phase_i (phase_r),
    .sin2_o  (sin2)
  );

  // Back end: scale by inv_beta, round half up (an arithmetic shift gives
  // the floor after the half-LSB offset), then add x and saturate.
  assign rnd_nxt = scl_r + 50'sd32768;
  assign sum_nxt = 35'(x_f2_r) + 35'(term_r);

  always_ff @(posedge clk) begin
    scl_r  <= 50'($signed({1'b0, sin2})) * 50'(b_ln_r[ALIGN_DEPTH-1]);
    x_f1_r <= x_ln_r[ALIGN_DEPTH-1];
    term_r <= 34'(rnd_nxt >>> 16);
    x_f2_r <= x_f1_r;
    if (sum_nxt > 35'sd2147483647) begin
      y_r   <= 32'sh7FFF_FFFF;
      ovf_r <= 1'b1;
    end else if (sum_nxt < -35'sd2147483648) begin
      y_r   <= 32'sh8000_0000;
      ovf_r <= 1'b1;
    end else begin
      y_r   <= sum_nxt[31:0];
      ovf_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_y_out    = y_r;
  assign out_overflow = ovf_r;

endmodule

@@ rtl/snk_checker.sv @@
module snk_checker
  import snk_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] in_sample_x,
  input logic signed [31:0] in_inv_beta,
  input logic               out_valid,
  input logic signed [31:0] out_y_out,
  input logic               out_overflow
);

  // Every accepted transaction yields its result a fixed time later.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##CORE_LAT out_valid)
    else $error("result missing at expected latency");

  // No result appears without an accepted transaction behind it.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##CORE_LAT !out_valid)
    else $error("result without accepted input");

  // Overflow only comes with a saturated value.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |->
      (out_y_out == 32'sh7FFF_FFFF || out_y_out == 32'sh8000_0000))
    else $error("overflow without saturated output");

  // A zero scale passes x straight through.
  a_zero_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && !busy && in_inv_beta == 32'sd0, CORE_LAT)) |->
      (out_y_out == $past(in_sample_x, CORE_LAT) && !out_overflow))
    else $error("zero inv_beta did not pass x through");

endmodule

bind snake_activation_core snk_checker u_snk_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_sample_x  (in_sample_x),
  .in_inv_beta  (in_inv_beta),
  .out_valid    (out_valid),
  .out_y_out    (out_y_out),
  .out_overflow (out_overflow)
);

@@ test/snake_activation_core_tb.sv @@
module snake_activation_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Operand item presented on the input channel.
  typedef struct packed {
    logic signed [31:0] sample_x;
    logic signed [31:0] alpha;
    logic signed [31:0] inv_beta;
  } snake_operands_t;

  // Result item as it leaves the core.
  typedef struct packed {
    logic signed [31:0] y_out;
    logic               overflow;
  } snake_result_t;

  localparam logic [63:0] TURN_PER_RAD = 64'h28BE60DB9391054A;
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam logic [63:0] ONE_Q30      = 64'd1073741824;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 60;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic signed [31:0]  in_sample_x;
  logic signed [31:0]  in_alpha;
  logic signed [31:0]  in_inv_beta;
  logic                out_valid;
  logic signed [31:0]  out_y_out;
  logic                out_overflow;

  snake_operands_t pending_operands[$];
  snake_result_t   expected_results[$];
  int unsigned     mismatch_count;
  int unsigned     cycle_count;
  bit              stimulus_done;
  bit              hold_sender;
  bit              no_idle_stretch;

  snake_activation_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_sample_x  (in_sample_x),
    .in_alpha     (in_alpha),
    .in_inv_beta  (in_inv_beta),
    .out_valid    (out_valid),
    .out_y_out    (out_y_out),
    .out_overflow (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Turn fraction of |alpha*x|: bits 64..95 of the magnitude times 1/(2*pi).
  function automatic logic [31:0] phase_of_product(input logic [63:0] mag);
    logic [127:0] full;
    full = {64'd0, mag} * {64'd0, TURN_PER_RAD};
    return full[95:64];
  endfunction

  // sin^2 of a turn fraction in Q16.16, folded to a quarter wave and
  // evaluated with a truncated Taylor series in Horner form.
  function automatic logic [63:0] sine_squared_q16(input logic [31:0] phase);
    logic [63:0] v, th, t, h, s, sq;
    v = {33'd0, phase[30:0]};
    if (v > ONE_Q30) begin
      v = 2 * ONE_Q30 - v;
    end
    th = (v * HALF_PI_Q30) >> 30;
    t  = (th * th) >> 30;
    h  = ONE_Q30 - t / 110;
    h  = ONE_Q30 - ((t * h) >> 30) / 72;
    h  = ONE_Q30 - ((t * h) >> 30) / 42;
    h  = ONE_Q30 - ((t * h) >> 30) / 20;
    h  = ONE_Q30 - ((t * h) >> 30) / 6;
    s  = (th * h) >> 30;
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    sq = (s * s) >> 30;
    sq = (sq + 64'd8192) >> 14;
    if (sq > 64'd65536) begin
      sq = 64'd65536;
    end
    return sq;
  endfunction

  // Full activation: x plus the scaled sine term, rounded and saturated.
  function automatic snake_result_t snake_activation(input snake_operands_t op);
    logic signed [63:0] x, a, b, prod, s2, scaled, term, total;
    logic [63:0]        mag;
    snake_result_t      res;
    x = op.sample_x;
    a = op.alpha;
    b = op.inv_beta;
    prod = a * x;
    mag  = (prod < 0) ? 64'(-prod) : 64'(prod);
    s2   = $signed(sine_squared_q16(phase_of_product(mag)));
    scaled = s2 * b + 64'sd32768;
    // Rounding is half up toward +inf: floor division of the biased value.
    term  = scaled >>> 16;
    total = x + term;
    res.overflow = 1'b0;
    if (total > 64'sd2147483647) begin
      res.y_out = 32'h7FFFFFFF;
      res.overflow = 1'b1;
    end else if (total < -64'sd2147483648) begin
      res.y_out = 32'h80000000;
      res.overflow = 1'b1;
    end else begin
      res.y_out = total[31:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  function automatic logic [31:0] random_operand();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        return 32'h7FFFFFFF - $urandom_range(0, 3);
      end
      1: begin
        return 32'h80000000 + $urandom_range(0, 3);
      end
      2, 3: begin
        // Values in [-2.0, 2.0] keep a product of two such operands under one turn.
        return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  task automatic queue_operands(input logic [31:0] x, input logic [31:0] a,
                                input logic [31:0] b);
    snake_operands_t op;
    op.sample_x = x;
    op.alpha    = a;
    op.inv_beta = b;
    pending_operands.push_back(op);
  endtask

  // Driver: pops an item whenever the previous one was taken, idling about
  // 22 percent of the time outside the no-idle stretch.
  always @(posedge clk) begin
    snake_operands_t op;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(snake_activation({in_sample_x, in_alpha, in_inv_beta}));
      end
      if (!(start && busy)) begin
        if (pending_operands.size() != 0 && !hold_sender &&
            (no_idle_stretch || $urandom_range(0, 99) >= 22)) begin
          op = pending_operands.pop_front();
          in_sample_x <= op.sample_x;
          in_alpha    <= op.alpha;
          in_inv_beta <= op.inv_beta;
          start       <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result transaction is checked against the oldest
  // prediction.
  always @(posedge clk) begin
    snake_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result y=%h", out_y_out));
      end else begin
        want = expected_results.pop_front();
        if (out_y_out !== want.y_out) begin
          report_mismatch($sformatf("y_out %h, expected %h", out_y_out, want.y_out));
        end
        if (out_overflow !== want.overflow) begin
          report_mismatch($sformatf("overflow %b, expected %b", out_overflow,
                                    want.overflow));
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("snake_activation_core test failed");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    rst_n = 1'b0;
    start = 1'b0;
    in_sample_x = '0;
    in_alpha    = '0;
    in_inv_beta = '0;
    mismatch_count = 0;
    cycle_count = 0;
    stimulus_done = 1'b0;
    hold_sender = 1'b1;
    no_idle_stretch = 1'b0;

    // Directed items: field extremes, zero product, negative product, and
    // sums that saturate at either end of the range.
    queue_operands(32'h0, 32'h0, 32'h0);
    queue_operands(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    queue_operands(32'h80000000, 32'h80000000, 32'h80000000);
    queue_operands(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    queue_operands(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    queue_operands(32'h7FFFFFFF, 32'h0001_0000, 32'h7FFFFFFF);
    queue_operands(32'h80000000, 32'h0001_0000, 32'h80000000);
    queue_operands(32'h7FFF0000, 32'h0001_921F, 32'h0100_0000);
    queue_operands(32'h8001_0000, 32'h0001_921F, 32'hFF00_0000);
    queue_operands(32'h0001_0000, 32'h0001_921F, 32'h0001_0000);
    queue_operands(32'hFFFF_0000, 32'h0001_921F, 32'h0001_0000);
    queue_operands(32'h0001_0000, 32'hFFFE_6DE1, 32'hFFFF_0000);
    queue_operands(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_operands(32'h0003_243F, 32'h0001_0000, 32'h7FFFFFFF);
    queue_operands(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_operands(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_operands(32'h0000_8000, 32'h0000_8000, 32'h8000_0000);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    hold_sender <= 1'b0;

    // Pause the sender until the directed items have all drained.
    wait (pending_operands.size() == 0);
    @(posedge clk);
    hold_sender <= 1'b1;
    wait (expected_results.size() == 0);
    @(posedge clk);
    hold_sender <= 1'b0;

    for (n = 0; n < 1450; n++) begin
      queue_operands(random_operand(), random_operand(), random_operand());
    end
    // Back-to-back stretch somewhere in the middle of the random part.
    wait (pending_operands.size() < 900);
    no_idle_stretch <= 1'b1;
    wait (pending_operands.size() < 600);
    no_idle_stretch <= 1'b0;

    wait (pending_operands.size() == 0);
    @(posedge clk);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("snake_activation_core test passed");
    end else begin
      $display("snake_activation_core test failed");
    end
    $finish;
  end

endmodule
